### hw/rtl/ffea_pkg.sv
// Package for the first-fit extent allocator.
// Holds sizes, status codes and the sequencer state type; no dependencies.
package ffea_pkg;
	localparam int MaxExtents   = 64;
	localparam int IdxBits      = $clog2(MaxExtents);
	localparam int CntBits      = IdxBits + 1;
	localparam int PosBits      = 32;
	localparam int LenBits      = 32;
	localparam int EntryBits    = PosBits + LenBits;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_EXTEND = 2'd1,
		ST_FULL   = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CK,
		S_PREV_CK,
		S_DECIDE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_TAIL_RD,
		S_TAIL_CK,
		S_RESP
	} state_t;
endpackage

### hw/rtl/first_fit_extent_allocator_top.sv
// First-fit extent allocator, top level.
// Uses ffea_pkg and one ffea_ram instance for the extent table.
//
// The block holds an address-ordered table of up to 64 free extents
// (start, length) in one RAM, plus an end pointer. One transaction in, one
// transaction out. Allocate scans from entry 0 for the first extent at
// least as large as size; exact fit removes the entry (table shifted down),
// larger trims its front, no fit grants the end pointer and grows it.
// Free finds the insert point by scanning, checks overlap with both
// neighbors, merges where the extents abut, else shifts the tail up and
// inserts; finally a last extent ending at the end pointer is dropped and
// the end pointer pulled back. The scan reads each entry up to the hit or
// insert point, and the shift reads and rewrites each entry from there to
// the end of the table. One request is in flight at a time; in_stall is
// high while busy and the result register holds until taken. Writing
// cfg_wdata with cfg_we loads the end pointer; no clearing pass is needed
// after reset.
module first_fit_extent_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [31:0]                 cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        operation,
	input  logic [31:0]                 position,
	input  logic [31:0]                 size,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [31:0]                 start_res,
	output logic [1:0]                  status,
	output logic [31:0]                 end_position
);
	import ffea_pkg::*;

	state_t state_q, state_d;

	logic               op_q;
	logic [PosBits-1:0] pos_q;
	logic [LenBits-1:0] size_q;
	logic [PosBits-1:0] end_q;
	logic [CntBits-1:0] cnt_q;
	logic [CntBits-1:0] idx_q;     // scan index / insert point
	logic [CntBits-1:0] sh_q;      // shift walker
	logic               sh_up_q;   // 1: shift up (insert), 0: shift down (drop)
	logic [PosBits-1:0] pst_q;     // previous extent
	logic [LenBits-1:0] pln_q;
	logic               have_prev_q;
	logic [EntryBits-1:0] put_q;   // entry to write at idx after shift
	logic [PosBits-1:0] grant_q;
	status_t            stat_q;
	logic               out_valid_q;

	// RAM port
	logic                 ram_we;
	logic [IdxBits-1:0]   ram_addr;
	logic [EntryBits-1:0] ram_wdata, ram_rdata;
	logic [PosBits-1:0]   rd_st;
	logic [LenBits-1:0]   rd_ln;

	assign rd_st = ram_rdata[EntryBits-1:LenBits];
	assign rd_ln = ram_rdata[LenBits-1:0];

	ffea_ram #(.Width(EntryBits), .Depth(MaxExtents)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// free checks against the next extent (read data at idx) and previous
	logic               nxt_ok;     // idx < cnt
	logic               nxt_eq, nxt_ovl, prv_ovl, bad_range;
	logic               mp, mn;
	logic [LenBits:0]   sum_p, sum_n;
	logic [PosBits-1:0] m_st;
	logic [LenBits-1:0] m_ln;

	always_comb begin
		nxt_ok    = (idx_q < cnt_q);
		bad_range = (size_q == '0) || ((size_q - 32'd1) > (~pos_q));
		nxt_eq    = nxt_ok && (rd_st == pos_q);
		prv_ovl   = have_prev_q && (pln_q > (pos_q - pst_q));
		nxt_ovl   = nxt_ok && (size_q > (rd_st - pos_q));
		sum_p     = {1'b0, pln_q} + {1'b0, size_q};
		mp        = have_prev_q && (pln_q == (pos_q - pst_q)) && !sum_p[LenBits];
		m_st      = mp ? pst_q : pos_q;
		m_ln      = mp ? sum_p[LenBits-1:0] : size_q;
		sum_n     = {1'b0, m_ln} + {1'b0, rd_ln};
		mn        = nxt_ok && ((rd_st - m_st) == m_ln) && !sum_n[LenBits];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (!op_q && size_q == '0) begin
					state_d = S_RESP;
				end else if (op_q && bad_range) begin
					state_d = S_RESP;
				end else if (idx_q < cnt_q) begin
					state_d = S_SCAN_CK;
				end else if (op_q) begin
					state_d = S_DECIDE;
				end else begin
					state_d = S_RESP;
				end
			end
			S_SCAN_CK: begin
				if (!op_q) begin
					state_d = (rd_ln >= size_q) ?
						((rd_ln == size_q) ? S_SHIFT_RD : S_RESP) : S_SCAN_RD;
				end else begin
					state_d = (rd_st < pos_q) ? S_SCAN_RD : S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (nxt_eq || prv_ovl || nxt_ovl) begin
					state_d = S_RESP;
				end else if (mp && mn) begin
					state_d = S_SHIFT_RD;
				end else if (mp || mn) begin
					state_d = S_TAIL_RD;
				end else if (cnt_q >= CntBits'(MaxExtents)) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_SHIFT_RD: begin
				if (sh_up_q) begin
					state_d = (sh_q > idx_q) ? S_SHIFT_WR : S_PUT;
				end else begin
					state_d = (sh_q + 1'b1 < cnt_q) ? S_SHIFT_WR : S_TAIL_RD;
				end
			end
			S_SHIFT_WR:  state_d = S_SHIFT_RD;
			S_PUT:       state_d = S_TAIL_RD;
			S_TAIL_RD:   state_d = (op_q && cnt_q != '0) ? S_TAIL_CK : S_RESP;
			S_TAIL_CK:   state_d = S_RESP;
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = idx_q[IdxBits-1:0];
		ram_wdata = put_q;
		case (state_q)
			S_SCAN_RD: ram_addr = idx_q[IdxBits-1:0];
			S_SCAN_CK: begin
				ram_addr = idx_q[IdxBits-1:0] - 1'b1;
				if (!op_q && rd_ln > size_q) begin
					ram_we    = 1'b1;
					ram_wdata = {rd_st + size_q, rd_ln - size_q};
				end
			end
			S_DECIDE: begin
				// idx entry (when present) was read in the last check
				ram_addr = idx_q[IdxBits-1:0];
				if (!(nxt_eq || prv_ovl || nxt_ovl)) begin
					if (mp && !mn) begin
						ram_we    = 1'b1;
						ram_addr  = idx_q[IdxBits-1:0] - 1'b1;
						ram_wdata = {pst_q, m_ln};
					end else if (mn && !mp) begin
						ram_we    = 1'b1;
						ram_wdata = {m_st, sum_n[LenBits-1:0]};
					end else if (mp && mn) begin
						ram_we    = 1'b1;
						ram_addr  = idx_q[IdxBits-1:0] - 1'b1;
						ram_wdata = {pst_q, sum_n[LenBits-1:0]};
					end
				end
			end
			S_SHIFT_RD: begin
				ram_addr = sh_up_q ? (sh_q[IdxBits-1:0] - 1'b1) : (sh_q[IdxBits-1:0] + 1'b1);
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_addr  = sh_q[IdxBits-1:0];
				ram_wdata = ram_rdata;
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_addr  = idx_q[IdxBits-1:0];
				ram_wdata = put_q;
			end
			S_TAIL_RD: ram_addr = cnt_q[IdxBits-1:0] - 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			end_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESP && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				end_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q        <= operation;
						pos_q       <= position;
						size_q      <= size;
						idx_q       <= '0;
						have_prev_q <= 1'b0;
						grant_q     <= '0;
						stat_q      <= ST_DONE;
					end
				end
				S_SCAN_RD: begin
					if (op_q && bad_range) begin
						stat_q <= ST_BAD;
					end else if (!op_q && size_q != '0 && idx_q >= cnt_q) begin
						grant_q <= end_q;
						end_q   <= end_q + size_q;
						stat_q  <= ST_EXTEND;
					end
					// stays at the insert point once the table end is reached
					if (idx_q < cnt_q) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SCAN_CK: begin
					idx_q <= idx_q - 1'b1;
					if (!op_q) begin
						if (rd_ln >= size_q) begin
							grant_q <= rd_st;
							sh_q    <= idx_q - 1'b1;
							sh_up_q <= 1'b0;
						end else begin
							idx_q <= idx_q;
						end
					end else if (rd_st < pos_q) begin
						idx_q       <= idx_q;
						have_prev_q <= 1'b1;
						pst_q       <= rd_st;
						pln_q       <= rd_ln;
					end
				end
				S_DECIDE: begin
					if (nxt_eq || prv_ovl || nxt_ovl) begin
						stat_q <= ST_BAD;
					end else if (mp && mn) begin
						sh_q    <= idx_q;
						sh_up_q <= 1'b0;
					end else if (!mp && !mn) begin
						if (cnt_q >= CntBits'(MaxExtents)) begin
							stat_q <= ST_FULL;
						end else begin
							sh_q    <= cnt_q;
							sh_up_q <= 1'b1;
							put_q   <= {pos_q, size_q};
						end
					end
				end
				S_SHIFT_RD: begin
					if (sh_up_q) begin
						if (!(sh_q > idx_q)) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (!(sh_q + 1'b1 < cnt_q)) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_SHIFT_WR: begin
					sh_q <= sh_up_q ? sh_q - 1'b1 : sh_q + 1'b1;
				end
				S_TAIL_CK: begin
					if (end_q >= rd_st && (end_q - rd_st) == rd_ln) begin
						end_q <= rd_st;
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						start_res    <= grant_q;
						status       <= stat_q;
						end_position <= end_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
endmodule

### hw/rtl/ffea_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ffea_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
